// File: rtl/core/bra_pkg.sv
// Shared definitions for the bitmap run allocator: request kinds, result codes,
// configuration register indexes and reset values.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bra_pkg;

	localparam int DEF_WORD_COUNT = 4096;
	localparam int DEF_MAP_WIDTH  = 32;

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_MARK    = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_NO_RUN  = 2'd2;

	localparam logic [1:0] REG_DATA_BASE    = 2'd0;
	localparam logic [1:0] REG_REGION_LIMIT = 2'd1;
	localparam logic [1:0] REG_WORD_SHIFT   = 2'd2;
	localparam logic [1:0] REG_WORDS_IN_USE = 2'd3;

	localparam logic [31:0] RST_DATA_BASE    = 32'd0;
	localparam logic [31:0] RST_REGION_LIMIT = 32'd0;
	localparam logic [3:0]  RST_WORD_SHIFT   = 4'd2;
	localparam logic [12:0] RST_WORDS_IN_USE = 13'd4096;

	localparam logic [31:0] NO_ADDRESS = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// File: rtl/core/bitmap_run_allocator.sv
// Bitmap run allocator: occupancy bitmap memory, next-fit scan cursor and the
// sequencer that drives one shared row evaluation unit. Depends on bra_pkg.
//
// Usage:
// Requests arrive on the s_axis channel: tuser carries the kind (allocate,
// mark, release), tdata the byte offset and byte length. Each request gives
// exactly one result on m_axis: tuser is the status, tdata the run address.
// Configuration registers are to be written on the cfg channel only while the block
// is idle; the block itself does not enforce this. cfg_ready is always high.
// One request is handled at a time. The shared unit evaluates one bitmap row
// of MAP_WIDTH words per cycle from a memory with a registered read port.
// A mark or release reads and rewrites every bitmap row in its range. An allocate
// scans from the next-fit cursor and, if no run is found and the cursor is not at
// word zero, searches again from word zero. Rejected, empty or out-of-range
// requests skip the bitmap. The result sits in an output register, so the next
// request is accepted while the receiver stalls; a finished result then waits
// until the register is free. After reset the bitmap is cleared one row per
// cycle; s_axis_tready stays low until every row is clear.
// MAP_WIDTH must be a power of two.
`default_nettype none

module bitmap_run_allocator import bra_pkg::*; #(
	parameter int WORD_COUNT = DEF_WORD_COUNT,
	parameter int MAP_WIDTH  = DEF_MAP_WIDTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // byte_offset[31:0], byte_length[63:32]
	input  wire logic [1:0]  s_axis_tuser,  // op[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // run_address[31:0]
	output logic [1:0]       m_axis_tuser,  // status[1:0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [31:0] cfg_data
);

	localparam int MAP_DEPTH = (WORD_COUNT + MAP_WIDTH - 1) / MAP_WIDTH;
	localparam int MAP_SH    = $clog2(MAP_WIDTH);
	localparam int ROW_W     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int POS_W     = ROW_W + MAP_SH + 1;
	localparam int IDX_W     = $clog2(WORD_COUNT);
	localparam int TW        = (POS_W > 13) ? POS_W : 13;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_PREP   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_RMW    = 3'd5;
	localparam logic [2:0] S_ADDR   = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [MAP_WIDTH-1:0] map_mem [MAP_DEPTH];

	logic [2:0]           state_q;
	logic [1:0]           op_q;
	logic [31:0]          off_q;
	logic [31:0]          len_q;
	logic [31:0]          data_base_q;
	logic [31:0]          region_limit_q;
	logic [3:0]           word_shift_q;
	logic [12:0]          words_in_use_q;
	logic [32:0]          need_q;
	logic [31:0]          start_q;
	logic                 bad_q;
	logic [POS_W-1:0]     lo_q;
	logic [POS_W-1:0]     hi_q;
	logic                 pass2_q;
	logic [ROW_W:0]       rd_row_q;
	logic [ROW_W-1:0]     row_s1;
	logic                 vld_s1;
	logic [MAP_WIDTH-1:0] rd_data_s1;
	logic [POS_W-1:0]     carry_q;
	logic [IDX_W-1:0]     cursor_q;
	logic [POS_W-1:0]     first_q;
	logic [1:0]           res_status_q;
	logic [31:0]          res_addr_q;
	logic                 m_valid_q;
	logic [1:0]           m_status_q;
	logic [31:0]          m_addr_q;

	logic [POS_W-1:0]     total_w;
	logic [POS_W-1:0]     need_w;
	logic [ROW_W-1:0]     last_row;
	logic [POS_W-1:0]     hi_m1;
	logic                 rd_en;
	logic [POS_W-1:0]     base_s1;
	logic [MAP_WIDTH-1:0] row_mask;
	logic [MAP_WIDTH-1:0] eff;
	logic                 any_hit;
	logic [MAP_SH-1:0]    hit_pos;
	logic                 any_one;
	logic [MAP_SH-1:0]    top_pos;
	logic [POS_W-1:0]     carry_run;
	logic [POS_W-1:0]     carry_next;
	logic [POS_W-1:0]     hit_idx;
	logic [POS_W-1:0]     cur_pos;
	logic [33:0]          end_sum;
	logic [POS_W-1:0]     end_pos;
	logic                 wr_en;
	logic [ROW_W-1:0]     wr_row;
	logic [MAP_WIDTH-1:0] wr_data;
	logic [32:0]          ws_mask;

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_addr_q;
	assign m_axis_tuser  = m_status_q;

	always_comb begin
		if (TW'(words_in_use_q) > TW'(WORD_COUNT)) begin
			total_w = POS_W'(WORD_COUNT);
		end else begin
			total_w = POS_W'(words_in_use_q);
		end
		need_w   = need_q[POS_W-1:0];
		hi_m1    = hi_q - POS_W'(1);
		last_row = hi_m1[MAP_SH +: ROW_W];
		cur_pos  = POS_W'(cursor_q);
		ws_mask  = (33'd1 << word_shift_q) - 33'd1;
		end_sum  = {2'b00, start_q} + {1'b0, need_q};
		if (end_sum > 34'(WORD_COUNT)) begin
			end_pos = POS_W'(WORD_COUNT);
		end else begin
			end_pos = end_sum[POS_W-1:0];
		end
		rd_en = ((state_q == S_SCAN) || (state_q == S_RMW))
			&& (rd_row_q <= {1'b0, last_row});
	end

	// Shared row unit: range mask, free-run search and trailing free count.
	always_comb begin
		logic [POS_W-1:0]     pos;
		logic [MAP_WIDTH-1:0] win;
		base_s1 = POS_W'({row_s1, {MAP_SH{1'b0}}});
		for (int b = 0; b < MAP_WIDTH; b++) begin
			pos = base_s1 + POS_W'(b);
			row_mask[b] = (pos >= lo_q) && (pos < hi_q);
		end
		eff = rd_data_s1 | ~row_mask;
		any_hit = 1'b0;
		hit_pos = '0;
		for (int b = MAP_WIDTH - 1; b >= 0; b--) begin
			for (int j = 0; j < MAP_WIDTH; j++) begin
				win[j] = (j <= b) && (POS_W'(b - j) < need_w);
			end
			if (((eff & win) == '0)
				&& (({1'b0, carry_q} + (POS_W + 1)'(b + 1)) >= {1'b0, need_w})) begin
				any_hit = 1'b1;
				hit_pos = MAP_SH'(b);
			end
		end
		any_one = 1'b0;
		top_pos = '0;
		for (int b = 0; b < MAP_WIDTH; b++) begin
			if (eff[b]) begin
				any_one = 1'b1;
				top_pos = MAP_SH'(b);
			end
		end
		if (any_one) begin
			carry_run = POS_W'(MAP_WIDTH - 1) - POS_W'(top_pos);
		end else begin
			carry_run = carry_q + POS_W'(MAP_WIDTH);
		end
		carry_next = (carry_run > need_w) ? need_w : carry_run;
		hit_idx    = base_s1 + POS_W'(hit_pos);
	end

	always_comb begin
		wr_en = (state_q == S_CLEAR) || ((state_q == S_RMW) && vld_s1);
		if (state_q == S_CLEAR) begin
			wr_row  = rd_row_q[ROW_W-1:0];
			wr_data = '0;
		end else begin
			wr_row = row_s1;
			if (op_q == OP_MARK) begin
				wr_data = rd_data_s1 | row_mask;
			end else begin
				wr_data = rd_data_s1 & ~row_mask;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_row] <= wr_data;
		end
		rd_data_s1 <= map_mem[rd_row_q[ROW_W-1:0]];
		row_s1     <= rd_row_q[ROW_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_base_q    <= RST_DATA_BASE;
			region_limit_q <= RST_REGION_LIMIT;
			word_shift_q   <= RST_WORD_SHIFT;
			words_in_use_q <= RST_WORDS_IN_USE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_addr)
				REG_DATA_BASE:    data_base_q    <= cfg_data;
				REG_REGION_LIMIT: region_limit_q <= cfg_data;
				REG_WORD_SHIFT:   word_shift_q   <= cfg_data[3:0];
				REG_WORDS_IN_USE: words_in_use_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			rd_row_q     <= '0;
			vld_s1       <= 1'b0;
			cursor_q     <= '0;
			m_valid_q    <= 1'b0;
			m_status_q   <= ST_OK;
			m_addr_q     <= NO_ADDRESS;
			op_q         <= OP_ALLOC;
			off_q        <= '0;
			len_q        <= '0;
			need_q       <= '0;
			start_q      <= '0;
			bad_q        <= 1'b0;
			lo_q         <= '0;
			hi_q         <= '0;
			pass2_q      <= 1'b0;
			carry_q      <= '0;
			first_q      <= '0;
			res_status_q <= ST_OK;
			res_addr_q   <= NO_ADDRESS;
		end else begin
			vld_s1 <= rd_en;
			if (rd_en) begin
				rd_row_q <= rd_row_q + 1'b1;
			end
			if (m_valid_q && m_axis_tready && (state_q != S_DONE)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					rd_row_q <= rd_row_q + 1'b1;
					if (rd_row_q[ROW_W-1:0] == ROW_W'(MAP_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q    <= s_axis_tuser;
						off_q   <= s_axis_tdata[31:0];
						len_q   <= s_axis_tdata[63:32];
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					need_q  <= ({1'b0, len_q} + ws_mask) >> word_shift_q;
					bad_q   <= (off_q < data_base_q)
						|| (({1'b0, off_q} + {1'b0, len_q}) > {1'b0, region_limit_q});
					start_q <= (off_q - data_base_q) >> word_shift_q;
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					res_addr_q <= NO_ADDRESS;
					carry_q    <= '0;
					if (op_q == OP_ALLOC) begin
						if ((len_q == '0) || (need_q > 33'(total_w))) begin
							res_status_q <= ST_INVALID;
							state_q      <= S_DONE;
						end else if (cur_pos < total_w) begin
							lo_q     <= cur_pos;
							hi_q     <= total_w;
							rd_row_q <= {1'b0, cur_pos[MAP_SH +: ROW_W]};
							pass2_q  <= (cursor_q != '0);
							state_q  <= S_SCAN;
						end else begin
							lo_q     <= '0;
							hi_q     <= total_w;
							rd_row_q <= '0;
							pass2_q  <= 1'b0;
							state_q  <= S_SCAN;
						end
					end else if ((op_q == OP_MARK) || (op_q == OP_RELEASE)) begin
						if (bad_q) begin
							res_status_q <= ST_INVALID;
							state_q      <= S_DONE;
						end else if ((len_q == '0) || (start_q >= 32'(WORD_COUNT))) begin
							res_status_q <= ST_OK;
							state_q      <= S_DONE;
						end else begin
							lo_q     <= start_q[POS_W-1:0];
							hi_q     <= end_pos;
							rd_row_q <= {1'b0, start_q[MAP_SH +: ROW_W]};
							state_q  <= S_RMW;
						end
					end else begin
						res_status_q <= ST_INVALID;
						state_q      <= S_DONE;
					end
				end
				S_SCAN: begin
					if (vld_s1) begin
						if (any_hit) begin
							cursor_q <= hit_idx[IDX_W-1:0];
							first_q  <= hit_idx - need_w + POS_W'(1);
							state_q  <= S_ADDR;
						end else if (row_s1 == last_row) begin
							if (pass2_q) begin
								lo_q     <= '0;
								hi_q     <= cur_pos;
								rd_row_q <= '0;
								carry_q  <= '0;
								pass2_q  <= 1'b0;
							end else begin
								res_status_q <= ST_NO_RUN;
								state_q      <= S_DONE;
							end
						end else begin
							carry_q <= carry_next;
						end
					end
				end
				S_RMW: begin
					if (vld_s1 && (row_s1 == last_row)) begin
						res_status_q <= ST_OK;
						state_q      <= S_DONE;
					end
				end
				S_ADDR: begin
					res_status_q <= ST_OK;
					res_addr_q   <= data_base_q + (32'(first_q) << word_shift_q);
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q  <= 1'b1;
						m_status_q <= res_status_q;
						m_addr_q   <= res_addr_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/bra_checker.sv
// Port-level checker for the bitmap run allocator, bound to the top level.
// Depends on bra_pkg and on the ports of bitmap_run_allocator.
`default_nettype none

module bra_checker import bra_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser
);

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result changed");

	// Only the three defined status codes are reported.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_INVALID)
			|| (m_axis_tuser == ST_NO_RUN))
		else $error("undefined status code");

	// A failed request never carries an address.
	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata == NO_ADDRESS)
		else $error("address reported with a failing status");

	// One request at a time: the block is busy right after taking a request.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while a request is in flight");

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: tb/sv/bitmap_run_allocator_tb.sv
// Self-checking testbench for bitmap_run_allocator: directed and random allocate,
// mark and release requests under several register settings, checked against an
// in-bench next-fit bitmap predictor. Depends on bra_pkg and the block's RTL.
`default_nettype none

module bitmap_run_allocator_tb;
	import bra_pkg::*;

	localparam int          MAP_BITS    = DEF_WORD_COUNT;
	localparam logic [1:0]  OP_UNUSED   = 2'd3;
	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned DRAIN_WAIT  = 200;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] off;
		logic [31:0] len;
	} request_t;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] addr;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;  // byte_offset[31:0], byte_length[63:32]
	logic [1:0]  s_axis_tuser = '0;  // op[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;       // run_address[31:0]
	logic [1:0]  m_axis_tuser;       // status[1:0]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_addr = '0;
	logic [31:0] cfg_data = '0;

	request_t    queued_requests[$];
	result_t     pending_results[$];
	request_t    on_bus;
	result_t     oldest;
	int unsigned idle_pct = 20;
	int unsigned fail_count = 0;
	int unsigned requests_issued = 0;
	int unsigned results_matched = 0;
	int unsigned quiet_cycles = 0;

	logic [MAP_BITS-1:0] occ_map = '0;
	int unsigned         fit_cursor = 0;
	logic [31:0]         cur_base = RST_DATA_BASE;
	logic [31:0]         cur_limit = RST_REGION_LIMIT;
	logic [3:0]          cur_shift = RST_WORD_SHIFT;
	logic [12:0]         cur_wiu = RST_WORDS_IN_USE;

	bitmap_run_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] words_covering(logic [31:0] bytes);
		logic [63:0] unit;
		unit = 64'd1 << cur_shift;
		return ({32'd0, bytes} + unit - 64'd1) >> cur_shift;
	endfunction

	function automatic logic [1:0] update_range(logic [31:0] off, logic [31:0] len, logic val);
		logic [63:0] start_w;
		logic [63:0] stop_w;
		if (off < cur_base || {32'd0, off} + {32'd0, len} > {32'd0, cur_limit})
			return ST_INVALID;
		if (len == 32'd0)
			return ST_OK;
		start_w = {32'd0, off - cur_base} >> cur_shift;
		stop_w = start_w + words_covering(len);
		if (stop_w > MAP_BITS)
			stop_w = MAP_BITS;
		for (logic [63:0] i = start_w; i < stop_w; i++)
			occ_map[i] = val;
		return ST_OK;
	endfunction

	function automatic logic find_run(int unsigned from_w, int unsigned to_w, logic [63:0] need,
			output logic [31:0] addr);
		logic [63:0] run;
		logic [63:0] byte_addr;
		run = '0;
		addr = NO_ADDRESS;
		for (int unsigned i = from_w; i < to_w; i++) begin
			if (!occ_map[i])
				run++;
			else
				run = '0;
			if (run >= need) begin
				fit_cursor = i;
				byte_addr = {32'd0, cur_base} + ((64'(i) + 64'd1 - need) << cur_shift);
				addr = byte_addr[31:0];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [1:0] try_allocate(logic [31:0] len, output logic [31:0] addr);
		int unsigned total;
		int unsigned start_c;
		logic [63:0] need;
		addr = NO_ADDRESS;
		total = (cur_wiu > MAP_BITS) ? MAP_BITS : cur_wiu;
		need = words_covering(len);
		start_c = fit_cursor;
		if (len == 32'd0 || need > total)
			return ST_INVALID;
		if (find_run(start_c, total, need, addr))
			return ST_OK;
		if (start_c > 0 && find_run(0, (start_c < total) ? start_c : total, need, addr))
			return ST_OK;
		addr = NO_ADDRESS;
		return ST_NO_RUN;
	endfunction

	function automatic result_t allocator_result(request_t rq);
		result_t r;
		r.addr = NO_ADDRESS;
		case (rq.op)
			OP_ALLOC:   r.status = try_allocate(rq.len, r.addr);
			OP_MARK:    r.status = update_range(rq.off, rq.len, 1'b1);
			OP_RELEASE: r.status = update_range(rq.off, rq.len, 1'b0);
			default:    r.status = ST_INVALID;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				pending_results.push_back(allocator_result(on_bus));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (queued_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
					on_bus = queued_requests.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= on_bus.op;
					s_axis_tdata <= {on_bus.len, on_bus.off};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					$error("result with nothing pending: status %0d, run_address %h",
						m_axis_tuser, m_axis_tdata);
					fail_count++;
				end else begin
					oldest = pending_results.pop_front();
					results_matched++;
					if (m_axis_tuser !== oldest.status) begin
						$error("status: expected %0d, got %0d", oldest.status, m_axis_tuser);
						fail_count++;
					end
					if (m_axis_tdata !== oldest.addr) begin
						$error("run_address: expected %h, got %h", oldest.addr, m_axis_tdata);
						fail_count++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready)
				&& !(cfg_valid && cfg_ready))
			quiet_cycles <= quiet_cycles + 1;
		else
			quiet_cycles <= 0;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic queue_request(logic [1:0] op, logic [31:0] off, logic [31:0] len);
		request_t rq;
		rq.op = op;
		rq.off = off;
		rq.len = len;
		queued_requests.push_back(rq);
		requests_issued++;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (results_matched != requests_issued)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DATA_BASE:    cur_base = val;
			REG_REGION_LIMIT: cur_limit = val;
			REG_WORD_SHIFT:   cur_shift = val[3:0];
			REG_WORDS_IN_USE: cur_wiu = val[12:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [31:0] base, logic [31:0] lim, logic [3:0] sh,
			logic [12:0] wiu);
		write_reg(REG_DATA_BASE, base);
		write_reg(REG_REGION_LIMIT, lim);
		write_reg(REG_WORD_SHIFT, {28'd0, sh});
		write_reg(REG_WORDS_IN_USE, {19'd0, wiu});
		cfg_valid <= 1'b0;
	endtask

	// Most requests address whole words inside the region so that marks and
	// releases shape the bitmap that later allocations have to search.
	task automatic queue_random(logic [31:0] base, logic [3:0] sh, int unsigned wiu);
		int unsigned pick;
		int unsigned idx;
		int unsigned nw;
		int unsigned ubytes;
		logic [63:0] off;
		logic [63:0] len;
		logic [1:0]  op;
		pick = $urandom_range(99);
		ubytes = 1 << sh;
		idx = $urandom_range(wiu - 1);
		nw = ($urandom_range(3) == 0) ? $urandom_range(wiu, 1) : $urandom_range(6, 1);
		off = {32'd0, base} + (64'(idx) << sh);
		if ($urandom_range(3) == 0)
			off = off + $urandom_range(ubytes - 1);
		len = 64'(nw) << sh;
		if ($urandom_range(3) == 0)
			len = len - $urandom_range(ubytes - 1);
		if (pick < 35) begin
			op = OP_MARK;
		end else if (pick < 60) begin
			op = OP_RELEASE;
		end else if (pick < 93) begin
			op = OP_ALLOC;
			if ($urandom_range(19) == 0)
				len = 64'(wiu + 1) << sh;
			else if ($urandom_range(29) == 0)
				len = '0;
		end else begin
			op = 2'($urandom_range(3));
			off = {32'd0, $urandom};
			len = ($urandom_range(1) == 1) ? {32'd0, $urandom} : 64'd0;
		end
		queue_request(op, off[31:0], len[31:0]);
	endtask

	initial begin
		logic [31:0] g_base;
		logic [63:0] g_end;
		logic [3:0]  g_shift;
		int unsigned g_wiu;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		queue_request(OP_ALLOC, 32'd0, 32'd0);
		queue_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_request(OP_MARK, 32'd0, 32'd0);
		queue_request(OP_MARK, 32'd0, 32'd1);
		queue_request(OP_ALLOC, 32'd0, 32'd16385);
		queue_request(OP_ALLOC, 32'd0, 32'd16384);
		queue_request(OP_ALLOC, 32'd0, 32'd1);
		wait_drained();

		// Large base so that run addresses wrap around the top of the space.
		set_config(32'hFFFF_0000, 32'hFFFF_FFFF, 4'd12, 13'd4096);
		queue_request(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
		queue_request(OP_MARK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_request(OP_MARK, 32'hFFFF_0000, 32'h0000_FFFF);
		queue_request(OP_ALLOC, 32'd0, 32'd1);
		queue_request(OP_ALLOC, 32'd0, 32'd81920);
		queue_request(OP_MARK, 32'd0, 32'd1);
		wait_drained();

		// The cursor now lies beyond the words in use, and a mark runs off the bitmap.
		set_config(32'd0, 32'hFFFF_FFFF, 4'd0, 13'd30);
		queue_request(OP_MARK, 32'd4090, 32'd100);
		queue_request(OP_ALLOC, 32'd0, 32'd10);
		queue_request(OP_RELEASE, 32'd0, 32'd0);
		queue_request(OP_RELEASE, 32'd0, 32'd16);
		queue_request(OP_ALLOC, 32'd0, 32'd30);
		queue_request(OP_MARK, 32'd0, 32'd30);
		queue_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd1);
		queue_request(OP_RELEASE, 32'd0, 32'hFFFF_FFFF);
		wait_drained();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					g_base = 32'd0;
					g_shift = 4'd2;
					g_wiu = 4096;
				end
				1: begin
					g_base = $urandom & 32'hFFFF_F000;
					g_shift = 4'd0;
					g_wiu = 64;
				end
				2: begin
					g_base = 32'h8000_0000 | ($urandom & 32'h0FFF_F000);
					g_shift = 4'd12;
					g_wiu = 4096;
				end
				3: begin
					g_base = $urandom;
					g_shift = 4'd5;
					g_wiu = 1;
				end
				4: begin
					g_base = 32'hFFFF_FFFF;
					g_shift = 4'($urandom_range(12));
					g_wiu = $urandom_range(4096, 1);
				end
				default: begin
					g_base = $urandom;
					g_shift = 4'($urandom_range(12));
					g_wiu = $urandom_range(4096, 1);
				end
			endcase
			g_end = {32'd0, g_base} + (64'(g_wiu) << g_shift);
			if ($urandom_range(3) == 0)
				g_end = g_end - ((64'(g_wiu) << g_shift) >> 1);
			if (p == 0 || g_end > 64'h0000_0000_FFFF_FFFF)
				g_end = 64'h0000_0000_FFFF_FFFF;
			idle_pct = (p == 0) ? 0 : 20;
			set_config(g_base, g_end[31:0], g_shift, 13'(g_wiu));
			repeat (85)
				queue_random(g_base, g_shift, g_wiu);
			wait_drained();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
